// ----- rtl/obbov_pkg.sv -----
package obbov_pkg;

  localparam int unsigned NUM_EDGES = 4;
  localparam int unsigned NUM_PAIRS = 10;

  typedef logic signed [31:0] coord_t;
  typedef logic signed [32:0] diff_t;
  typedef logic signed [63:0] eprod_t;
  typedef logic signed [64:0] cprod_t;
  typedef logic        [63:0] mag_t;
  typedef logic        [65:0] ext_t;
  typedef logic        [64:0] cen2_t;

  // unordered edge pairs, each dot product computed once
  localparam int unsigned PAIR_A [NUM_PAIRS] = '{0, 0, 0, 0, 1, 1, 1, 2, 2, 3};
  localparam int unsigned PAIR_B [NUM_PAIRS] = '{0, 1, 2, 3, 1, 2, 3, 2, 3, 3};

  localparam int unsigned PAIR_OF [NUM_EDGES][NUM_EDGES] = '{
    '{0, 1, 2, 3},
    '{1, 4, 5, 6},
    '{2, 5, 7, 8},
    '{3, 6, 8, 9}
  };

endpackage

// ----- rtl/obbov_mul.sv -----
module obbov_mul (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  valid_i,
  input  obbov_pkg::coord_t     ex_i [obbov_pkg::NUM_EDGES],
  input  obbov_pkg::coord_t     ey_i [obbov_pkg::NUM_EDGES],
  input  obbov_pkg::diff_t      dx_i,
  input  obbov_pkg::diff_t      dy_i,
  output logic                  valid_o,
  output obbov_pkg::eprod_t     pex_o [obbov_pkg::NUM_PAIRS],
  output obbov_pkg::eprod_t     pey_o [obbov_pkg::NUM_PAIRS],
  output obbov_pkg::cprod_t     pcx_o [obbov_pkg::NUM_EDGES],
  output obbov_pkg::cprod_t     pcy_o [obbov_pkg::NUM_EDGES]
);

  logic              valid_r;
  obbov_pkg::eprod_t pex_r [obbov_pkg::NUM_PAIRS];
  obbov_pkg::eprod_t pey_r [obbov_pkg::NUM_PAIRS];
  obbov_pkg::cprod_t pcx_r [obbov_pkg::NUM_EDGES];
  obbov_pkg::cprod_t pcy_r [obbov_pkg::NUM_EDGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  // edge by edge products
  always_ff @(posedge clk) begin
    for (int k = 0; k < obbov_pkg::NUM_PAIRS; k++) begin
      pex_r[k] <= ex_i[obbov_pkg::PAIR_A[k]] * ex_i[obbov_pkg::PAIR_B[k]];
      pey_r[k] <= ey_i[obbov_pkg::PAIR_A[k]] * ey_i[obbov_pkg::PAIR_B[k]];
    end
  end

  // center difference by edge products
  always_ff @(posedge clk) begin
    for (int i = 0; i < obbov_pkg::NUM_EDGES; i++) begin
      pcx_r[i] <= dx_i * ex_i[i];
      pcy_r[i] <= dy_i * ey_i[i];
    end
  end

  assign valid_o = valid_r;
  assign pex_o   = pex_r;
  assign pey_o   = pey_r;
  assign pcx_o   = pcx_r;
  assign pcy_o   = pcy_r;

endmodule

// ----- rtl/obbov_ext.sv -----
module obbov_ext (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  valid_i,
  input  obbov_pkg::eprod_t     pex_i [obbov_pkg::NUM_PAIRS],
  input  obbov_pkg::eprod_t     pey_i [obbov_pkg::NUM_PAIRS],
  input  obbov_pkg::cprod_t     pcx_i [obbov_pkg::NUM_EDGES],
  input  obbov_pkg::cprod_t     pcy_i [obbov_pkg::NUM_EDGES],
  output logic                  valid_o,
  output obbov_pkg::ext_t       ext_o [obbov_pkg::NUM_EDGES],
  output obbov_pkg::cen2_t      cen2_o [obbov_pkg::NUM_EDGES]
);

  logic                valid_abs_r;
  logic                valid_r;
  obbov_pkg::mag_t     dmag_nxt [obbov_pkg::NUM_PAIRS];
  obbov_pkg::mag_t     dmag_r   [obbov_pkg::NUM_PAIRS];
  obbov_pkg::mag_t     cmag_nxt [obbov_pkg::NUM_EDGES];
  obbov_pkg::mag_t     cmag_r   [obbov_pkg::NUM_EDGES];
  obbov_pkg::ext_t     ext_nxt  [obbov_pkg::NUM_EDGES];
  obbov_pkg::ext_t     ext_r    [obbov_pkg::NUM_EDGES];
  obbov_pkg::cen2_t    cen2_r   [obbov_pkg::NUM_EDGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_abs_r <= 1'b0;
      valid_r     <= 1'b0;
    end else begin
      valid_abs_r <= valid_i;
      valid_r     <= valid_abs_r;
    end
  end

  // dot products and their magnitudes
  always_comb begin
    logic signed [64:0] dsum;
    logic signed [65:0] csum;
    for (int k = 0; k < obbov_pkg::NUM_PAIRS; k++) begin
      dsum = {pex_i[k][63], pex_i[k]} + {pey_i[k][63], pey_i[k]};
      dmag_nxt[k] = dsum[64] ? 64'(-dsum) : dsum[63:0];
    end
    for (int i = 0; i < obbov_pkg::NUM_EDGES; i++) begin
      csum = {pcx_i[i][64], pcx_i[i]} + {pcy_i[i][64], pcy_i[i]};
      cmag_nxt[i] = csum[65] ? 64'(-csum) : csum[63:0];
    end
  end

  always_ff @(posedge clk) begin
    dmag_r <= dmag_nxt;
    cmag_r <= cmag_nxt;
  end

  // extent along each axis
  always_comb begin
    for (int i = 0; i < obbov_pkg::NUM_EDGES; i++) begin
      ext_nxt[i] = (66'(dmag_r[obbov_pkg::PAIR_OF[i][0]])
                  + 66'(dmag_r[obbov_pkg::PAIR_OF[i][1]]))
                 + (66'(dmag_r[obbov_pkg::PAIR_OF[i][2]])
                  + 66'(dmag_r[obbov_pkg::PAIR_OF[i][3]]));
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < obbov_pkg::NUM_EDGES; i++) begin
      ext_r[i]  <= ext_nxt[i];
      cen2_r[i] <= {cmag_r[i], 1'b0};
    end
  end

  assign valid_o = valid_r;
  assign ext_o   = ext_r;
  assign cen2_o  = cen2_r;

endmodule

// ----- rtl/obb_2d_overlap_test.sv -----
// channel   ports                         transaction
// input     start, busy, in_*             start high and busy low at a rising edge
// result    out_valid, out_overlap        out_valid high for one cycle
//
// one box pair per cycle; busy is always low
// result is registered in the compare stage, in the order of acceptance
// stages: input/center difference, multipliers, dot magnitudes, extents, compare
// synchronous active-low reset clears the valid bits only
// the receiver cannot stall, so the pipeline never holds
module obb_2d_overlap_test (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_left_xaxis_x,
  input  logic [31:0] in_left_xaxis_y,
  input  logic [31:0] in_left_yaxis_x,
  input  logic [31:0] in_left_yaxis_y,
  input  logic [31:0] in_left_center_x,
  input  logic [31:0] in_left_center_y,
  input  logic [31:0] in_right_xaxis_x,
  input  logic [31:0] in_right_xaxis_y,
  input  logic [31:0] in_right_yaxis_x,
  input  logic [31:0] in_right_yaxis_y,
  input  logic [31:0] in_right_center_x,
  input  logic [31:0] in_right_center_y,
  output logic        out_valid,
  output logic        out_overlap
);

  logic              in_valid_r;
  obbov_pkg::coord_t ex_r [obbov_pkg::NUM_EDGES];
  obbov_pkg::coord_t ey_r [obbov_pkg::NUM_EDGES];
  obbov_pkg::diff_t  dx_r;
  obbov_pkg::diff_t  dy_r;

  logic              mul_valid;
  obbov_pkg::eprod_t pex [obbov_pkg::NUM_PAIRS];
  obbov_pkg::eprod_t pey [obbov_pkg::NUM_PAIRS];
  obbov_pkg::cprod_t pcx [obbov_pkg::NUM_EDGES];
  obbov_pkg::cprod_t pcy [obbov_pkg::NUM_EDGES];

  logic              ext_valid;
  obbov_pkg::ext_t   ext  [obbov_pkg::NUM_EDGES];
  obbov_pkg::cen2_t  cen2 [obbov_pkg::NUM_EDGES];

  logic              sep;
  logic              out_valid_r;
  logic              out_overlap_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    ex_r[0] <= $signed(in_left_xaxis_x);
    ey_r[0] <= $signed(in_left_xaxis_y);
    ex_r[1] <= $signed(in_left_yaxis_x);
    ey_r[1] <= $signed(in_left_yaxis_y);
    ex_r[2] <= $signed(in_right_xaxis_x);
    ey_r[2] <= $signed(in_right_xaxis_y);
    ex_r[3] <= $signed(in_right_yaxis_x);
    ey_r[3] <= $signed(in_right_yaxis_y);
    dx_r    <= $signed({in_right_center_x[31], in_right_center_x})
             - $signed({in_left_center_x[31], in_left_center_x});
    dy_r    <= $signed({in_right_center_y[31], in_right_center_y})
             - $signed({in_left_center_y[31], in_left_center_y});
  end

  obbov_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_valid_r),
    .ex_i    (ex_r),
    .ey_i    (ey_r),
    .dx_i    (dx_r),
    .dy_i    (dy_r),
    .valid_o (mul_valid),
    .pex_o   (pex),
    .pey_o   (pey),
    .pcx_o   (pcx),
    .pcy_o   (pcy)
  );

  obbov_ext u_ext (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (mul_valid),
    .pex_i   (pex),
    .pey_i   (pey),
    .pcx_i   (pcx),
    .pcy_i   (pcy),
    .valid_o (ext_valid),
    .ext_o   (ext),
    .cen2_o  (cen2)
  );

  // any axis where extent < 2 * center term separates the boxes
  always_comb begin
    sep = 1'b0;
    for (int i = 0; i < obbov_pkg::NUM_EDGES; i++) begin
      if (ext[i] < {1'b0, cen2[i]}) begin
        sep = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ext_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_overlap_r <= ~sep;
  end

  assign out_valid   = out_valid_r;
  assign out_overlap = out_overlap_r;

endmodule
